/* sv/letterbox_detection_box_decode_top_macros.svh */
// assertion macros shared by the checker of the box decoder
`ifndef LETTERBOX_DETECTION_BOX_DECODE_TOP_MACROS_SVH
`define LETTERBOX_DETECTION_BOX_DECODE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define LBD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lbd_pkg.sv */
// shared widths, register indexes and structs of the box decoder
package lbd_pkg;

    // field widths
    localparam int IMG_W    = 13;
    localparam int NET_W    = 12;
    localparam int COORD_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int LABEL_W  = 7;
    localparam int EDGE_W   = 13;
    localparam int PROD_W   = IMG_W + NET_W;

    // stream and register port widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;
    localparam int ADDR_W     = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // divider operand widths
    localparam int DVD_W = 31;
    localparam int DVS_W = IMG_W;

    // job queue depth
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NET_WIDTH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NET_HEIGHT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCORE_THRESH = 3'd4;

    // one kept proposal waiting for the mapping
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } t_job;

    // frame and network sizes, zero already forced to one
    typedef struct packed {
        logic [IMG_W-1:0] iw;
        logic [IMG_W-1:0] ih;
        logic [NET_W-1:0] nw;
        logic [NET_W-1:0] nh;
    } t_geom;

    // one decoded box
    typedef struct packed {
        logic [EDGE_W-1:0]  left;
        logic [EDGE_W-1:0]  top;
        logic [EDGE_W-1:0]  width;
        logic [EDGE_W-1:0]  height;
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } t_result;

    // divider request and response
    typedef struct packed {
        logic             valid;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
    } t_div_rsp;

endpackage

/* sv/lbd_front.sv */
// score front end: running best class per proposal and threshold decision
module lbd_front #(
    parameter int CLASS_COUNT = 80
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lbd_pkg::COORD_W-1:0] i_cx,
    input  logic [lbd_pkg::COORD_W-1:0] i_cy,
    input  logic [lbd_pkg::COORD_W-1:0] i_w,
    input  logic [lbd_pkg::COORD_W-1:0] i_h,
    input  logic [lbd_pkg::SCORE_W-1:0] i_score,
    input  logic                        i_last,
    input  logic [lbd_pkg::SCORE_W-1:0] i_threshold,
    input  logic                        i_full,
    output logic                        o_push,
    output lbd_pkg::t_job               o_job
);
    import lbd_pkg::*;

    localparam int CIDX_W = $clog2(CLASS_COUNT + 1);

    logic [CIDX_W-1:0]  r_class_index, n_class_index;
    logic [CIDX_W-1:0]  r_best_class, n_best_class;
    logic [SCORE_W-1:0] r_best_score, n_best_score;
    logic [COORD_W-1:0] r_cx, r_cy, r_w, r_h;
    logic [COORD_W-1:0] n_cx, n_cy, n_w, n_h;
    logic               w_accept;
    logic               w_first;
    logic               w_in_range;

    // a beat is taken whenever the queue has room
    assign o_ready    = !i_full;
    assign w_accept   = i_valid && o_ready;
    assign w_first    = (r_class_index == '0);
    assign w_in_range = (r_class_index < CIDX_W'(CLASS_COUNT));

    // running maximum, first maximum wins ties
    always_comb begin
        n_class_index = r_class_index;
        n_best_score  = r_best_score;
        n_best_class  = r_best_class;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_w           = r_w;
        n_h           = r_h;
        if (w_first) begin
            n_cx         = i_cx;
            n_cy         = i_cy;
            n_w          = i_w;
            n_h          = i_h;
            n_best_score = i_score;
            n_best_class = '0;
        end else if (w_in_range && (i_score > r_best_score)) begin
            n_best_score = i_score;
            n_best_class = r_class_index;
        end
        if (w_in_range) begin
            n_class_index = r_class_index + 1'b1;
        end
        if (i_last) begin
            n_class_index = '0;
        end
    end

    // hand a kept proposal to the back end
    assign o_push      = w_accept && i_last && (n_best_score > i_threshold);
    assign o_job.cx    = n_cx;
    assign o_job.cy    = n_cy;
    assign o_job.w     = n_w;
    assign o_job.h     = n_h;
    assign o_job.label = LABEL_W'(n_best_class);
    assign o_job.score = n_best_score;

    // class counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_index <= '0;
        end else if (w_accept) begin
            r_class_index <= n_class_index;
        end
    end

    // best score and class, and the held box, which is rewritten on the first score
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_best_score <= n_best_score;
            r_best_class <= n_best_class;
            r_cx         <= n_cx;
            r_cy         <= n_cy;
            r_w          <= n_w;
            r_h          <= n_h;
        end
    end

endmodule

/* sv/lbd_queue.sv */
// short job queue between the score front end and the mapping back end
module lbd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lbd_pkg::t_job o_job
);
    import lbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/lbd_divider.sv */
// restoring unsigned divider, one quotient bit per cycle
module lbd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbd_pkg::t_div_req i_req,
    output lbd_pkg::t_div_rsp o_rsp
);
    import lbd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem, r_div;
    logic [DVS_W:0]   w_shift, w_trial;
    logic             w_ge;

    // shift in the next dividend bit and try the subtraction
    assign w_shift = {r_rem, r_quot[DVD_W-1]};
    assign w_trial = w_shift - {1'b0, r_div};
    assign w_ge    = !w_trial[DVS_W];

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_trial[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quot <= {r_quot[DVD_W-2:0], w_ge};
        end
    end

endmodule

/* sv/lbd_back.sv */
// mapping back end: letterbox removal, rescale and clamp of the left, right, top and bottom edges
module lbd_back #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lbd_pkg::t_geom   i_geom,
    input  logic             i_job_valid,
    input  lbd_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output lbd_pkg::t_result o_res
);
    import lbd_pkg::*;

    localparam int MUL_W = COORD_W + IMG_W;
    localparam int NUM_W = 32 + COORD_FRAC_BITS;
    localparam int PM_W  = DVD_W + IMG_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RATIO  = 11'b000_0000_0010,
        S_SELECT = 11'b000_0000_0100,
        S_PROD   = 11'b000_0000_1000,
        S_SUM    = 11'b000_0001_0000,
        S_DIV1   = 11'b000_0010_0000,
        S_MUL    = 11'b000_0100_0000,
        S_ISSUE  = 11'b000_1000_0000,
        S_DIV2   = 11'b001_0000_0000,
        S_NEXT   = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    t_job                r_job;
    logic [PROD_W-1:0]   r_pa, r_pb, r_pad;
    logic [IMG_W-1:0]    r_den;
    logic [NET_W-1:0]    r_ndom;
    logic                r_pad_y;
    logic [1:0]          r_edge;
    logic [MUL_W-1:0]    r_cd, r_sd;
    logic [DVD_W-1:0]    r_m;
    logic [EDGE_W-1:0]   r_edges [4];
    logic                r_out_valid;
    t_result             r_out;

    logic                w_axis_y, w_plus;
    logic [COORD_W-1:0]  w_c, w_s;
    logic [PROD_W-1:0]   w_pad;
    logic [IMG_W-1:0]    w_hi;
    logic signed [NUM_W-1:0] w_cd_ext, w_sd_ext, w_pad_sh, w_num;
    logic [NUM_W-1:0]    w_num_shr;
    logic                w_num_pos;
    logic [EDGE_W-1:0]   w_clamped;
    logic                w_emit;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    lbd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // edge order: left, right, top, bottom
    assign w_axis_y = r_edge[1];
    assign w_plus   = r_edge[0];
    assign w_c      = w_axis_y ? r_job.cy : r_job.cx;
    assign w_s      = w_axis_y ? r_job.h : r_job.w;
    assign w_pad    = (w_axis_y == r_pad_y) ? r_pad : '0;
    assign w_hi     = w_axis_y ? (i_geom.ih - IMG_W'(1)) : (i_geom.iw - IMG_W'(1));

    // numerator 2*c*den -+ s*den - 2^F*pad
    assign w_cd_ext  = NUM_W'(r_cd);
    assign w_sd_ext  = NUM_W'(r_sd);
    assign w_pad_sh  = NUM_W'(w_pad) << COORD_FRAC_BITS;
    assign w_num     = (w_cd_ext <<< 1) + (w_plus ? w_sd_ext : -w_sd_ext) - w_pad_sh;
    assign w_num_pos = !w_num[NUM_W-1] && (w_num != '0);
    assign w_num_shr = w_num >> (COORD_FRAC_BITS + 1);

    // clamp the rescaled edge to the frame
    assign w_clamped = (w_div_rsp.quot > DVD_W'(w_hi)) ? w_hi : w_div_rsp.quot[EDGE_W-1:0];

    // divider requests: network edge first, then the rescale
    always_comb begin
        w_div_req = '0;
        if ((r_state == S_SUM) && w_num_pos) begin
            w_div_req.valid    = 1'b1;
            w_div_req.dividend = w_num_shr[DVD_W-1:0];
            w_div_req.divisor  = r_den;
        end else if (r_state == S_ISSUE) begin
            w_div_req.valid    = 1'b1;
            w_div_req.dividend = r_m;
            w_div_req.divisor  = DVS_W'(r_ndom);
        end
    end

    assign o_pop   = (r_state == S_IDLE) && i_job_valid;
    assign w_emit  = (r_state == S_EMIT) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_job_valid) n_state = S_RATIO;
            S_RATIO:  n_state = S_SELECT;
            S_SELECT: n_state = S_PROD;
            S_PROD:   n_state = S_SUM;
            S_SUM:    n_state = w_num_pos ? S_DIV1 : S_NEXT;
            S_DIV1:   if (w_div_rsp.done) n_state = S_MUL;
            S_MUL:    n_state = S_ISSUE;
            S_ISSUE:  n_state = S_DIV2;
            S_DIV2:   if (w_div_rsp.done) n_state = S_NEXT;
            S_NEXT:   n_state = (r_edge == 2'd3) ? S_EMIT : S_PROD;
            S_EMIT:   if (w_emit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        // padding comes from the cross products of the sizes
        if (r_state == S_RATIO) begin
            r_pa <= PROD_W'(i_geom.nh) * PROD_W'(i_geom.iw);
            r_pb <= PROD_W'(i_geom.nw) * PROD_W'(i_geom.ih);
        end
        // smaller ratio picks the scaling axis
        if (r_state == S_SELECT) begin
            r_edge <= 2'd0;
            if (r_pa > r_pb) begin
                r_den   <= i_geom.iw;
                r_ndom  <= i_geom.nw;
                r_pad   <= r_pa - r_pb;
                r_pad_y <= 1'b1;
            end else begin
                r_den   <= i_geom.ih;
                r_ndom  <= i_geom.nh;
                r_pad   <= r_pb - r_pa;
                r_pad_y <= 1'b0;
            end
        end
        if (r_state == S_PROD) begin
            r_cd <= MUL_W'(w_c) * MUL_W'(r_den);
            r_sd <= MUL_W'(w_s) * MUL_W'(r_den);
        end
        // an edge left of or above the frame clamps to zero
        if ((r_state == S_SUM) && !w_num_pos) begin
            r_edges[r_edge] <= '0;
        end
        if ((r_state == S_MUL)) begin
            r_m <= DVD_W'(PM_W'(w_div_rsp.quot) * PM_W'(r_den));
        end
        if ((r_state == S_DIV2) && w_div_rsp.done) begin
            r_edges[r_edge] <= w_clamped;
        end
        if (r_state == S_NEXT) begin
            r_edge <= r_edge + 1'b1;
        end
        if (w_emit) begin
            r_out.left   <= r_edges[0];
            r_out.top    <= r_edges[2];
            r_out.width  <= r_edges[1] - r_edges[0];
            r_out.height <= r_edges[3] - r_edges[2];
            r_out.label  <= r_job.label;
            r_out.score  <= r_job.score;
        end
    end

endmodule

/* sv/letterbox_detection_box_decode_top.sv */
// top level of the letterbox detection box decoder
//
// Input stream: one beat per class score of a detection proposal; tdata carries
// the centre-form box (Q12.4) and the score (Q0.16), tlast marks the last score.
// The box is taken with the first score of each proposal.
// Output stream: one beat per kept proposal, the box in image pixels with label
// and score. Proposals whose best score is not above the threshold give no beat.
// Register port: five registers (frame size, network size, score threshold) at
// byte addresses 0, 4, 8, 12 and 16; write them only while the block is idle.
// Throughput: one score per cycle while the two-entry job queue has room.
// Each kept proposal runs up to eight divisions, two per edge, on the single
// shared divider, and the back end takes no new box until the result of the
// last one is in the output register.
// Reset: registers return to 640 x 480 frame, 640 x 640 network, threshold
// 0.25; the class counter and the queue are emptied.
// Output stall: the result beat holds; the back end waits with its next box,
// the queue fills and s_axis_tready falls once both queue entries are taken.
module letterbox_detection_box_decode_top #(
    parameter int CLASS_COUNT     = 80,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // score stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // box_cx, box_cy, box_w, box_h, class_score
    input  logic [lbd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // last_class
    input  logic                              s_axis_tlast,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // left, top, width, height, label, score, zero fill
    output logic [lbd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lbd_pkg::ADDR_W-1:0]        paddr,
    input  logic [lbd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lbd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import lbd_pkg::*;

    logic [IMG_W-1:0]     r_image_width, r_image_height;
    logic [NET_W-1:0]     r_net_width, r_net_height;
    logic [SCORE_W-1:0]   r_score_threshold;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;
    t_geom                w_geom;
    t_job                 w_push_job, w_pop_job;
    logic                 w_push, w_full, w_pop, w_job_valid;
    t_result              w_res;

    // register port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= IMG_W'(640);
            r_image_height    <= IMG_W'(480);
            r_net_width       <= NET_W'(640);
            r_net_height      <= NET_W'(640);
            r_score_threshold <= SCORE_W'(16384);
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_IMAGE_WIDTH:  r_image_width     <= pwdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height    <= pwdata[IMG_W-1:0];
                REG_NET_WIDTH:    r_net_width       <= pwdata[NET_W-1:0];
                REG_NET_HEIGHT:   r_net_height      <= pwdata[NET_W-1:0];
                REG_SCORE_THRESH: r_score_threshold <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            REG_NET_WIDTH:    prdata = APB_DATA_W'(r_net_width);
            REG_NET_HEIGHT:   prdata = APB_DATA_W'(r_net_height);
            REG_SCORE_THRESH: prdata = APB_DATA_W'(r_score_threshold);
            default:          prdata = '0;
        endcase
    end

    // a zero size counts as one
    assign w_geom.iw = (r_image_width == '0) ? IMG_W'(1) : r_image_width;
    assign w_geom.ih = (r_image_height == '0) ? IMG_W'(1) : r_image_height;
    assign w_geom.nw = (r_net_width == '0) ? NET_W'(1) : r_net_width;
    assign w_geom.nh = (r_net_height == '0) ? NET_W'(1) : r_net_height;

    lbd_front #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cx        (s_axis_tdata[15:0]),
        .i_cy        (s_axis_tdata[31:16]),
        .i_w         (s_axis_tdata[47:32]),
        .i_h         (s_axis_tdata[63:48]),
        .i_score     (s_axis_tdata[79:64]),
        .i_last      (s_axis_tlast),
        .i_threshold (r_score_threshold),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    lbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_pop_job)
    );

    lbd_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (w_geom),
        .i_job_valid (w_job_valid),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (w_res)
    );

    // result beat, left edge in the lowest bits
    assign m_axis_tdata = OUT_DATA_W'({w_res.score, w_res.label, w_res.height,
                                       w_res.width, w_res.top, w_res.left});

endmodule

/* sv/lbd_checker.sv */
// port-level checker of the box decoder and its bind
`include "letterbox_detection_box_decode_top_macros.svh"

module lbd_checker #(
    parameter int CLASS_COUNT = 80
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lbd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lbd_pkg::*;

    // a stalled result beat keeps its value
    `LBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // label names a class that exists
    `LBD_ASSERT_NOW(a_label_range, m_axis_tvalid, (CLASS_COUNT >= 128) || (m_axis_tdata[58:52] < 7'(CLASS_COUNT)), "label beyond class count")

    // right edge stays inside the largest frame
    `LBD_ASSERT_NOW(a_x_span, m_axis_tvalid, (14'(m_axis_tdata[12:0]) + 14'(m_axis_tdata[38:26])) < 14'd8191, "left plus width leaves the frame")

    // bottom edge stays inside the largest frame
    `LBD_ASSERT_NOW(a_y_span, m_axis_tvalid, (14'(m_axis_tdata[25:13]) + 14'(m_axis_tdata[51:39])) < 14'd8191, "top plus height leaves the frame")

endmodule

bind letterbox_detection_box_decode_top lbd_checker #(
    .CLASS_COUNT (CLASS_COUNT)
) u_lbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_letterbox_detection_box_decode_top.sv */
// testbench of the letterbox box decoder: directed and random proposals checked against a box predictor
`timescale 1ns / 100ps

module tb_letterbox_detection_box_decode_top;
    import lbd_pkg::*;

    localparam int CLASS_COUNT  = 80;
    localparam int COORD_FRAC   = 4;
    localparam int SETTLE_WAIT  = 400;
    localparam int LONG_STALL   = 1500;
    localparam int STUCK_LIMIT  = 20000;
    localparam int SHOWN_ERRORS = 10;

    // one score beat as offered on the input stream
    typedef struct {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_score_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // box_cx, box_cy, box_w, box_h, class_score
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // last_class
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // left, top, width, height, label, score, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    letterbox_detection_box_decode_top #(
        .CLASS_COUNT    (CLASS_COUNT),
        .COORD_FRAC_BITS(COORD_FRAC)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // register shadow, as written
    logic [IMG_W-1:0]   cfg_iw = 13'd640;
    logic [IMG_W-1:0]   cfg_ih = 13'd480;
    logic [NET_W-1:0]   cfg_nw = 12'd640;
    logic [NET_W-1:0]   cfg_nh = 12'd640;
    logic [SCORE_W-1:0] cfg_thr = 16'd16384;

    // proposal state of the predictor
    logic [SCORE_W-1:0] best_score = '0;
    logic [LABEL_W-1:0] best_class = '0;
    int                 class_idx = 0;
    logic [COORD_W-1:0] held_cx = '0;
    logic [COORD_W-1:0] held_cy = '0;
    logic [COORD_W-1:0] held_w = '0;
    logic [COORD_W-1:0] held_h = '0;

    t_score_beat score_beats[$];
    t_result     pending_boxes[$];

    int  send_idle_pct = 31;
    int  recv_idle_pct = 70;
    bit  hold_req = 1'b0;
    bit  hold_taken = 1'b0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    int  stuck_cycles = 0;
    int  mismatches = 0;
    int  boxes_seen = 0;

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // one network edge back to clamped image pixels, truncating toward zero
    function automatic longint map_to_pixels(longint c, longint s, bit plus, longint den,
                                             longint pad, longint ndom, longint hi);
        longint unit;
        longint num;
        longint on_net;
        longint pix;
        unit = longint'(1) << COORD_FRAC;
        num = 2 * c * den + (plus ? s * den : -(s * den)) - unit * pad;
        on_net = num / (2 * unit * den);
        pix = on_net * den / ndom;
        if (pix > hi) pix = hi;
        if (pix < 0) pix = 0;
        return pix;
    endfunction

    // running argmax over one proposal, box decode on the last score
    task automatic decode_score(input t_score_beat b);
        longint  iw, ih, nw, nh, den, ndom, padx, pady, l, r, t, bt;
        t_result box;
        if (class_idx == 0) begin
            held_cx = b.cx;
            held_cy = b.cy;
            held_w = b.w;
            held_h = b.h;
            best_score = b.score;
            best_class = '0;
        end else if (class_idx < CLASS_COUNT && b.score > best_score) begin
            best_score = b.score;
            best_class = class_idx[LABEL_W-1:0];
        end
        if (class_idx < CLASS_COUNT) class_idx++;
        if (b.last) begin
            class_idx = 0;
            if (best_score > cfg_thr) begin
                // zero sizes count as one
                iw = (cfg_iw == 0) ? 1 : longint'(cfg_iw);
                ih = (cfg_ih == 0) ? 1 : longint'(cfg_ih);
                nw = (cfg_nw == 0) ? 1 : longint'(cfg_nw);
                nh = (cfg_nh == 0) ? 1 : longint'(cfg_nh);
                if (nh * iw > nw * ih) begin
                    den = iw; ndom = nw; padx = 0; pady = nh * iw - nw * ih;
                end else begin
                    den = ih; ndom = nh; pady = 0; padx = nw * ih - nh * iw;
                end
                l = map_to_pixels(held_cx, held_w, 1'b0, den, padx, ndom, iw - 1);
                r = map_to_pixels(held_cx, held_w, 1'b1, den, padx, ndom, iw - 1);
                t = map_to_pixels(held_cy, held_h, 1'b0, den, pady, ndom, ih - 1);
                bt = map_to_pixels(held_cy, held_h, 1'b1, den, pady, ndom, ih - 1);
                box.left = l[EDGE_W-1:0];
                box.top = t[EDGE_W-1:0];
                box.width = EDGE_W'(r - l);
                box.height = EDGE_W'(bt - t);
                box.label = best_class;
                box.score = best_score;
                pending_boxes.insert(pending_boxes.size(), box);
            end
        end
    endtask

    task automatic flag_field(input string what, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("box %0d %s: expected %0d, got %0d", boxes_seen, what, want, got);
        end
    endtask

    // input driver: new beat at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        t_score_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (score_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                b = score_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {b.score, b.h, b.w, b.cy, b.cx};
                s_axis_tlast <= b.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold on request
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            stall_left <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted scores, check accepted boxes, watchdog
    always @(posedge i_clk) begin
        t_score_beat b;
        t_result     want;
        bit          in_beat;
        bit          out_beat;
        in_beat = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_beat = i_rst_n && m_axis_tvalid && m_axis_tready;
        in_taken <= in_beat;
        if (in_beat) begin
            b.cx = s_axis_tdata[15:0];
            b.cy = s_axis_tdata[31:16];
            b.w = s_axis_tdata[47:32];
            b.h = s_axis_tdata[63:48];
            b.score = s_axis_tdata[79:64];
            b.last = s_axis_tlast;
            decode_score(b);
        end
        if (out_beat) begin
            if (pending_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("box %0d: not expected, tdata %h", boxes_seen, m_axis_tdata);
            end else begin
                want = pending_boxes.pop_front();
                flag_field("left", want.left, m_axis_tdata[12:0]);
                flag_field("top", want.top, m_axis_tdata[25:13]);
                flag_field("width", want.width, m_axis_tdata[38:26]);
                flag_field("height", want.height, m_axis_tdata[51:39]);
                flag_field("label", want.label, m_axis_tdata[58:52]);
                flag_field("score", want.score, m_axis_tdata[74:59]);
            end
            boxes_seen++;
        end
        if (in_beat || out_beat || !i_rst_n) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("letterbox_detection_box_decode_top: mismatch");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_iw = val[IMG_W-1:0];
            REG_IMAGE_HEIGHT: cfg_ih = val[IMG_W-1:0];
            REG_NET_WIDTH:    cfg_nw = val[NET_W-1:0];
            REG_NET_HEIGHT:   cfg_nh = val[NET_W-1:0];
            REG_SCORE_THRESH: cfg_thr = val[SCORE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] iw, input logic [31:0] ih,
                                input logic [31:0] nw, input logic [31:0] nh,
                                input logic [31:0] thr);
        write_reg(REG_IMAGE_WIDTH, iw);
        write_reg(REG_IMAGE_HEIGHT, ih);
        write_reg(REG_NET_WIDTH, nw);
        write_reg(REG_NET_HEIGHT, nh);
        write_reg(REG_SCORE_THRESH, thr);
        @(posedge i_clk);
    endtask

    task automatic push_beat(input logic [15:0] cx, input logic [15:0] cy,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] score, input logic last);
        t_score_beat b;
        b.cx = cx; b.cy = cy; b.w = w; b.h = h; b.score = score; b.last = last;
        score_beats.insert(score_beats.size(), b);
    endtask

    // mostly plain random scores, sometimes values that tie or sit on the threshold
    function automatic logic [15:0] pick_score();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4) return 16'd0;
        if (r < 8) return 16'hFFFF;
        if (r < 12) return cfg_thr;
        if (r < 16) return (cfg_thr == 16'hFFFF) ? cfg_thr : cfg_thr + 16'd1;
        if (r < 24) return 16'h8000;
        return 16'($urandom);
    endfunction

    // coordinate inside the network frame most of the time
    function automatic logic [15:0] pick_coord(input logic [NET_W-1:0] span);
        int unsigned cap;
        cap = ((span == 0) ? 1 : span) * 16;
        if (cap > 65535) cap = 65535;
        if ($urandom_range(99) < 30) return 16'($urandom);
        return 16'($urandom_range(cap));
    endfunction

    // one proposal; only the first beat's box is latched, the rest carry noise
    task automatic push_proposal(input int n_scores);
        logic [15:0] cx, cy, w, h;
        cx = pick_coord(cfg_nw);
        cy = pick_coord(cfg_nh);
        w = pick_coord(cfg_nw);
        h = pick_coord(cfg_nh);
        for (int k = 0; k < n_scores; k++) begin
            if (k == 0)
                push_beat(cx, cy, w, h, pick_score(), n_scores == 1);
            else
                push_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          pick_score(), k == n_scores - 1);
        end
    endtask

    // wait for the queue and every expected box, then for the back end to go quiet
    task automatic drain_and_settle();
        while (score_beats.size() != 0 || s_axis_tvalid || pending_boxes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic random_proposals(input int n_items);
        int pushed;
        int len;
        int unsigned r;
        pushed = 0;
        while (pushed < n_items) begin
            r = $urandom_range(99);
            if (r < 62) len = $urandom_range(8, 1);
            else if (r < 90) len = $urandom_range(30, 9);
            else if (r < 96) len = CLASS_COUNT;
            else len = $urandom_range(CLASS_COUNT + 10, CLASS_COUNT + 1);
            push_proposal(len);
            pushed += len;
        end
    endtask

    // stimulus
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed proposals under the reset registers
        push_beat(16'd5120, 16'd5120, 16'd1600, 16'd1280, 16'hFFFF, 1'b1);
        push_beat(16'd5120, 16'd5120, 16'd1600, 16'd1280, 16'd16384, 1'b1);
        push_beat(16'd2000, 16'd7000, 16'd900, 16'd3000, 16'd16385, 1'b1);
        // equal scores keep the first class
        push_beat(16'd3000, 16'd3000, 16'd500, 16'd500, 16'h9000, 1'b0);
        push_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'h9000, 1'b1);
        push_beat(16'd8000, 16'd6000, 16'd2000, 16'd2500, 16'h1000, 1'b0);
        push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA000, 1'b0);
        push_beat(16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 16'hA000, 1'b1);
        // box at the origin and box at full scale, both clamp
        push_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
        push_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // zero score never passes
        push_beat(16'd4000, 16'd4000, 16'd800, 16'd800, 16'd0, 1'b1);
        push_beat(16'd9000, 16'd1000, 16'd3000, 16'd1500, 16'h5000, 1'b0);
        push_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'h6000, 1'b0);
        push_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'h7000, 1'b0);
        push_beat(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 1'b1);
        drain_and_settle();

        // landscape frame, width ratio wins
        set_geometry(32'd1920, 32'd1080, 32'd640, 32'd640, 32'h4000);
        push_proposal(CLASS_COUNT + 4);
        random_proposals(300);
        drain_and_settle();

        // largest sizes, threshold at zero
        set_geometry(32'd8191, 32'd8191, 32'd4095, 32'd4095, 32'd0);
        random_proposals(350);
        drain_and_settle();

        send_idle_pct = 70;
        recv_idle_pct = 31;
        // smallest sizes
        set_geometry(32'd1, 32'd1, 32'd1, 32'd1, 32'h8000);
        random_proposals(300);
        drain_and_settle();

        // zero sizes behind set upper bits
        set_geometry(32'hFFFF_E000, 32'hFFFF_E000, 32'hFFFF_F000, 32'hFFFF_F000,
                     32'hFFFF_0100);
        random_proposals(250);
        drain_and_settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // top threshold, nothing can pass
        set_geometry(32'd720, 32'd1280, 32'd416, 32'd320, 32'hFFFF);
        random_proposals(100);
        drain_and_settle();

        // portrait frame with the receiver held off long enough to fill the queue
        set_geometry(32'd480, 32'd640, 32'd640, 32'd640, 32'h2000);
        random_proposals(300);
        hold_req = 1'b1;
        drain_and_settle();

        // random registers
        set_geometry($urandom_range(8191, 1), $urandom_range(8191, 1),
                     $urandom_range(4095, 1), $urandom_range(4095, 1),
                     $urandom_range(16'hC000));
        random_proposals(250);
        drain_and_settle();

        if (mismatches == 0 && pending_boxes.size() == 0) begin
            $display("letterbox_detection_box_decode_top: match");
        end else begin
            $display("letterbox_detection_box_decode_top: mismatch");
        end
        $finish;
    end

endmodule
